// ----- rtl/edge_map_adaptive_threshold_unit_defines.svh -----
// Assertion macros used by the edge map top level.
`ifndef EDGE_MAP_ADAPTIVE_THRESHOLD_UNIT_DEFINES_SVH
`define EDGE_MAP_ADAPTIVE_THRESHOLD_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define EMAT_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("edge map check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define EMAT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("edge map check failed");

`else

`define EMAT_ASSERT_IMPLY(label, ante, cons)
`define EMAT_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- rtl/emat_pkg.sv -----
// Shared constants, types and helper functions of the edge map unit.
package emat_pkg;

    // Default sizes of the line stores, the row counter and the job queue.
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_QUEUE_DEPTH = 4;

    // Register reset values.
    localparam logic [8:0] RST_FRAME_WIDTH  = 9'd188;
    localparam logic [8:0] RST_FRAME_HEIGHT = 9'd120;
    localparam logic [7:0] RST_CONTRAST     = 8'd20;

    // Configuration address map (word index in paddr[3:2]).
    localparam int CFG_ADDR_W = 4;
    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_CONTRAST     = 2'd2;

    // Bit positions of the result mask of one job.
    localparam int RES_FIRST  = 0;
    localparam int RES_PREV   = 1;
    localparam int RES_CENTER = 2;
    localparam int RES_LAST   = 3;

    // Position flags carried along the front pipeline.
    typedef struct packed {
        logic       center;
        logic       first;
        logic       after_first;
        logic       last;
        logic [7:0] row;
        logic [7:0] col;
        logic [7:0] last_col;
    } pos_t;

    // One job: all results caused by one pixel.
    typedef struct packed {
        logic [7:0] row;
        logic [7:0] center_col;
        logic [7:0] last_col;
        logic       prev_black;
        logic       center_black;
        logic [3:0] mask;
    } job_t;

    // Sum of three pixels.
    function automatic logic [9:0] add3(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
        return 10'(a) + 10'(b) + 10'(c);
    endfunction

    // Absolute difference of two three-pixel sums.
    function automatic logic [9:0] abs_diff(input logic [9:0] pos, input logic [9:0] neg);
        return (pos >= neg) ? (pos - neg) : (neg - pos);
    endfunction

endpackage

// ----- rtl/emat_pixel_if.sv -----
// Pixel input channel: valid/ready handshake with pixel and frame start.
interface emat_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel;
    logic       frame_start;

    modport source (output valid, output pixel, output frame_start, input ready);
    modport sink (input valid, input pixel, input frame_start, output ready);
endinterface

// ----- rtl/emat_result_if.sv -----
// Result output channel: valid/ready handshake with one output pixel.
interface emat_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_row;
    logic [7:0] out_column;
    logic       is_black;
    logic       last_in_run;

    modport source (output valid, output out_row, output out_column, output is_black,
                    output last_in_run, input ready);
    modport sink (input valid, input out_row, input out_column, input is_black,
                  input last_in_run, output ready);
endinterface

// ----- rtl/emat_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module emat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read returns the contents before a write in the same cycle.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/emat_queue.sv -----
// Short job queue between the front pipeline and the result sequencer.
module emat_queue #(
    parameter int DEPTH = emat_pkg::DEF_QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  emat_pkg::job_t push_job,
    input  logic          pop,
    output emat_pkg::job_t head,
    output logic          full,
    output logic          empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    emat_pkg::job_t slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Job storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign head  = slot_reg[rd_ptr_reg];
    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);

endmodule

// ----- rtl/emat_front.sv -----
// Front pipeline: position counting, line stores, 3x3 window and edge decision.
module emat_front #(
    parameter int MAX_WIDTH  = emat_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = emat_pkg::DEF_MAX_HEIGHT
) (
    input  logic           clk,
    input  logic           rst_n,
    emat_pixel_if.sink     video,
    input  logic [8:0]     cfg_width,
    input  logic [8:0]     cfg_height,
    input  logic [7:0]     cfg_contrast,
    input  logic           queue_full,
    output logic           push,
    output emat_pkg::job_t push_job
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 1);

    // Limited frame size.
    logic [WW-1:0] w_lim;
    logic [RW-1:0] h_lim;

    // Position counters.
    logic [XW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;

    // Stage 0 signals.
    logic [XW-1:0] x_eff;
    logic [RW-1:0] r_eff;
    logic          drop;
    logic          take;
    logic          row_end;
    logic          en;
    emat_pkg::pos_t pos0;

    // Stage 1: line store data.
    logic           s1_valid_reg;
    logic [7:0]     s1_pix_reg;
    logic [XW-1:0]  s1_x_reg;
    logic           s1_byp_reg;
    emat_pkg::pos_t s1_pos_reg;
    logic [7:0]     byp_top_reg;
    logic [7:0]     byp_mid_reg;
    logic [7:0]     up_q;
    logic [7:0]     mid_q;
    logic [7:0]     top_val;
    logic [7:0]     mid_val;
    logic [7:0]     win_reg [6];
    logic [9:0]     g_comb [4];
    logic [11:0]    sum_comb;

    // Stage 2: direction responses.
    logic           s2_valid_reg;
    emat_pkg::pos_t s2_pos_reg;
    logic [9:0]     s2_g_reg [4];
    logic [11:0]    s2_sum_reg;
    logic [9:0]     max01;
    logic [9:0]     max23;
    logic [9:0]     gmax;

    // Stage 3: threshold decision.
    logic           s3_valid_reg;
    emat_pkg::pos_t s3_pos_reg;
    logic [9:0]     s3_gmax_reg;
    logic [11:0]    s3_sum_reg;
    logic [17:0]    prod;
    logic           edge_hit;
    logic           prev_edge_reg;
    logic           want_push;
    logic [3:0]     mask;

    // Frame size limited to the line store depth and row counter range.
    always_comb
    begin
        if (32'(cfg_width) > MAX_WIDTH)
        begin
            w_lim = WW'(MAX_WIDTH);
        end
        else
        begin
            w_lim = WW'(cfg_width);
        end
        if (32'(cfg_height) > MAX_HEIGHT)
        begin
            h_lim = RW'(MAX_HEIGHT);
        end
        else
        begin
            h_lim = RW'(cfg_height);
        end
    end

    // Stall the whole pipeline only when a job is waiting on a full queue.
    assign en          = !(s3_valid_reg && want_push && queue_full);
    assign video.ready = en;

    // Position of the incoming pixel and its classification.
    always_comb
    begin
        x_eff   = video.frame_start ? '0 : col_reg;
        r_eff   = video.frame_start ? '0 : row_reg;
        drop    = (r_eff >= h_lim);
        take    = video.valid && en && !drop;
        row_end = ((WW'(x_eff) + WW'(1)) >= w_lim);

        pos0.center      = (w_lim >= WW'(3)) && (h_lim >= RW'(3)) && (r_eff >= RW'(2))
                           && (x_eff >= XW'(2)) && (WW'(x_eff) < w_lim);
        pos0.first       = (x_eff == XW'(2));
        pos0.after_first = (x_eff >= XW'(3));
        pos0.last        = (WW'(x_eff) == (w_lim - WW'(1)));
        pos0.row         = 8'(r_eff - RW'(1));
        pos0.col         = 8'(x_eff - XW'(1));
        pos0.last_col    = 8'(w_lim - WW'(1));
    end

    // Next column and row counts.
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (video.valid && en)
        begin
            if (drop)
            begin
                col_next = x_eff;
                row_next = r_eff;
            end
            else if (row_end)
            begin
                col_next = '0;
                row_next = r_eff + RW'(1);
            end
            else
            begin
                col_next = x_eff + XW'(1);
                row_next = r_eff;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Line stores: read at acceptance, written back from stage 1.
    emat_ram #(
        .WIDTH(8),
        .DEPTH(MAX_WIDTH)
    ) u_upper (
        .clk  (clk),
        .we   (s1_valid_reg && en),
        .waddr(s1_x_reg),
        .wdata(mid_val),
        .re   (take),
        .raddr(x_eff),
        .rdata(up_q)
    );

    emat_ram #(
        .WIDTH(8),
        .DEPTH(MAX_WIDTH)
    ) u_middle (
        .clk  (clk),
        .we   (s1_valid_reg && en),
        .waddr(s1_x_reg),
        .wdata(s1_pix_reg),
        .re   (take),
        .raddr(x_eff),
        .rdata(mid_q)
    );

    // Stage 1, 2 and 3 valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= take;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // Stage 1 payload, with a bypass for a read that meets the write of the
    // pixel just ahead at the same column.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_pix_reg  <= video.pixel;
            s1_x_reg    <= x_eff;
            s1_pos_reg  <= pos0;
            s1_byp_reg  <= s1_valid_reg && (s1_x_reg == x_eff);
            byp_top_reg <= mid_val;
            byp_mid_reg <= s1_pix_reg;
        end
    end

    assign top_val = s1_byp_reg ? byp_top_reg : up_q;
    assign mid_val = s1_byp_reg ? byp_mid_reg : mid_q;

    // Window columns shift with every pixel that enters the pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (en && s1_valid_reg)
        begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= top_val;
            win_reg[4] <= mid_val;
            win_reg[5] <= s1_pix_reg;
        end
    end

    // Four direction responses and the window sum.
    always_comb
    begin
        g_comb[0] = emat_pkg::abs_diff(
            emat_pkg::add3(top_val, mid_val, s1_pix_reg),
            emat_pkg::add3(win_reg[0], win_reg[1], win_reg[2]));
        g_comb[1] = emat_pkg::abs_diff(
            emat_pkg::add3(win_reg[2], win_reg[5], s1_pix_reg),
            emat_pkg::add3(win_reg[0], win_reg[3], top_val));
        g_comb[2] = emat_pkg::abs_diff(
            emat_pkg::add3(win_reg[1], win_reg[5], win_reg[2]),
            emat_pkg::add3(win_reg[3], mid_val, top_val));
        g_comb[3] = emat_pkg::abs_diff(
            emat_pkg::add3(mid_val, win_reg[5], s1_pix_reg),
            emat_pkg::add3(win_reg[3], win_reg[1], win_reg[0]));
        sum_comb = 12'(emat_pkg::add3(win_reg[0], win_reg[1], win_reg[2]))
                 + 12'(emat_pkg::add3(win_reg[3], win_reg[4], win_reg[5]))
                 + 12'(emat_pkg::add3(top_val, mid_val, s1_pix_reg));
    end

    // Stage 2 and stage 3 payload.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_pos_reg  <= s1_pos_reg;
            s2_sum_reg  <= sum_comb;
            for (int i = 0; i < 4; i++)
            begin
                s2_g_reg[i] <= g_comb[i];
            end
            s3_pos_reg  <= s2_pos_reg;
            s3_gmax_reg <= gmax;
            s3_sum_reg  <= s2_sum_reg;
        end
    end

    // Largest response.
    assign max01 = (s2_g_reg[1] > s2_g_reg[0]) ? s2_g_reg[1] : s2_g_reg[0];
    assign max23 = (s2_g_reg[3] > s2_g_reg[2]) ? s2_g_reg[3] : s2_g_reg[2];
    assign gmax  = (max23 > max01) ? max23 : max01;

    // Threshold against the window sum.
    assign prod     = 18'(s3_gmax_reg) * 18'(cfg_contrast);
    assign edge_hit = (prod > 18'(s3_sum_reg));

    // Results due for this center.
    always_comb
    begin
        mask                      = '0;
        mask[emat_pkg::RES_FIRST]  = s3_pos_reg.first && edge_hit;
        mask[emat_pkg::RES_PREV]   = s3_pos_reg.after_first;
        mask[emat_pkg::RES_CENTER] = s3_pos_reg.last;
        mask[emat_pkg::RES_LAST]   = s3_pos_reg.last && edge_hit;
    end

    assign want_push = s3_pos_reg.center && (mask != '0);
    assign push      = s3_valid_reg && want_push && !queue_full;

    always_comb
    begin
        push_job.row          = s3_pos_reg.row;
        push_job.center_col   = s3_pos_reg.col;
        push_job.last_col     = s3_pos_reg.last_col;
        push_job.prev_black   = prev_edge_reg || edge_hit;
        push_job.center_black = edge_hit;
        push_job.mask         = mask;
    end

    // Edge flag of the previous center.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_edge_reg <= 1'b0;
        end
        else if (en && s3_valid_reg && s3_pos_reg.center)
        begin
            prev_edge_reg <= edge_hit;
        end
    end

endmodule

// ----- rtl/emat_back.sv -----
// Result sequencer: turns one job into up to three output pixels.
module emat_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           queue_empty,
    input  emat_pkg::job_t queue_head,
    output logic           pop,
    emat_result_if.source  edges
);

    emat_pkg::job_t cur_reg;
    logic [3:0]     mask_reg, mask_next;
    logic [3:0]     rest;
    logic           busy;
    logic           fire;
    logic           load;

    assign busy = (mask_reg != '0);
    assign rest = mask_reg & (mask_reg - 4'd1);
    assign fire = busy && edges.ready;
    assign load = !queue_empty && (!busy || (fire && (rest == '0)));
    assign pop  = load;

    // Pending results of the current job.
    always_comb
    begin
        mask_next = mask_reg;
        if (load)
        begin
            mask_next = queue_head.mask;
        end
        else if (fire)
        begin
            mask_next = rest;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else
        begin
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cur_reg <= queue_head;
        end
    end

    // Lowest pending result goes out first.
    always_comb
    begin
        edges.valid       = busy;
        edges.out_row     = cur_reg.row;
        edges.last_in_run = (rest == '0);
        priority if (mask_reg[emat_pkg::RES_FIRST])
        begin
            edges.out_column = '0;
            edges.is_black   = 1'b1;
        end
        else if (mask_reg[emat_pkg::RES_PREV])
        begin
            edges.out_column = cur_reg.center_col - 8'd1;
            edges.is_black   = cur_reg.prev_black;
        end
        else if (mask_reg[emat_pkg::RES_CENTER])
        begin
            edges.out_column = cur_reg.center_col;
            edges.is_black   = cur_reg.center_black;
        end
        else
        begin
            edges.out_column = cur_reg.last_col;
            edges.is_black   = 1'b1;
        end
    end

endmodule

// ----- rtl/edge_map_adaptive_threshold_unit.sv -----
// Top level of the streaming 3x3 edge map with contrast-relative threshold.
//
//  Channel  | Direction | Carries
//  ---------+-----------+-----------------------------------------------
//  video    | in        | pixel, frame_start (one request per pixel)
//  edges    | out       | out_row, out_column, is_black, last_in_run
//  APB      | in        | frame_width, frame_height, contrast_divisor
//
// A pixel is taken every clock unless the front pipeline stalls; its results, if
// any, pass the front pipeline and the job queue, one result per clock while ready.
// The output sequencer sets the sustained rate: a pixel causing n results
// holds the output until all n are taken; a four-entry job queue absorbs bursts.
// Reset clears counters, window, edge flag and queue; line stores need no clearing.
// When a job meets a full queue, the front pipeline and video.ready stall.
`include "edge_map_adaptive_threshold_unit_defines.svh"

module edge_map_adaptive_threshold_unit #(
    parameter int MAX_WIDTH   = emat_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = emat_pkg::DEF_MAX_HEIGHT,
    parameter int QUEUE_DEPTH = emat_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    emat_pixel_if.sink                      video,
    emat_result_if.source                   edges,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [emat_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    logic [8:0]     width_reg;
    logic [8:0]     height_reg;
    logic [7:0]     contrast_reg;
    logic           cfg_write;
    logic [1:0]     reg_index;
    logic           q_push;
    logic           q_pop;
    logic           q_full;
    logic           q_empty;
    emat_pkg::job_t push_job;
    emat_pkg::job_t head_job;

    // Configuration registers.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_index = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= emat_pkg::RST_FRAME_WIDTH;
            height_reg   <= emat_pkg::RST_FRAME_HEIGHT;
            contrast_reg <= emat_pkg::RST_CONTRAST;
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                emat_pkg::REG_FRAME_WIDTH:  width_reg    <= pwdata[8:0];
                emat_pkg::REG_FRAME_HEIGHT: height_reg   <= pwdata[8:0];
                emat_pkg::REG_CONTRAST:     contrast_reg <= pwdata[7:0];
                default:
                begin
                end
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        unique case (reg_index)
            emat_pkg::REG_FRAME_WIDTH:  prdata = 32'(width_reg);
            emat_pkg::REG_FRAME_HEIGHT: prdata = 32'(height_reg);
            emat_pkg::REG_CONTRAST:     prdata = 32'(contrast_reg);
            default:                    prdata = '0;
        endcase
    end

    emat_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .video       (video),
        .cfg_width   (width_reg),
        .cfg_height  (height_reg),
        .cfg_contrast(contrast_reg),
        .queue_full  (q_full),
        .push        (q_push),
        .push_job    (push_job)
    );

    emat_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_job(push_job),
        .pop     (q_pop),
        .head    (head_job),
        .full    (q_full),
        .empty   (q_empty)
    );

    emat_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .queue_empty(q_empty),
        .queue_head (head_job),
        .pop        (q_pop),
        .edges      (edges)
    );

    // A job is never written into a full queue.
    `EMAT_ASSERT_IMPLY(a_no_overflow, q_push, !q_full)
    // Input stalls only because the queue is full.
    `EMAT_ASSERT_IMPLY(a_stall_cause, !video.ready, q_full)
    // A queued job is presented on the output by the next cycle.
    `EMAT_ASSERT_NEXT(a_queue_drains, !q_empty, edges.valid)

endmodule

// ----- tb/sv/edge_map_adaptive_threshold_unit_tb.sv -----
// Self-checking testbench of the edge map unit: pixel stimulus, APB setup and result scoreboard.
module edge_map_adaptive_threshold_unit_tb;

    localparam int LINE_MAX      = 256;
    localparam int HEIGHT_MAX    = 256;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_LIMIT   = 3000;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [7:0] pixel;
        logic       frame_start;
    } pixel_req_t;

    typedef struct packed {
        logic [7:0] row;
        logic [7:0] col;
        logic       black;
        logic       last;
    } edge_pixel_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [emat_pkg::CFG_ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    emat_pixel_if video_ch ();
    emat_result_if edges_ch ();

    edge_map_adaptive_threshold_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .video   (video_ch),
        .edges   (edges_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Stimulus and scoreboard storage.
    pixel_req_t  pixels_to_send[$];
    edge_pixel_t pending_edge_pixels[$];
    pixel_req_t  next_req;
    int pixels_queued;
    int pixels_accepted;
    int fault_count;
    int quiet_cycles;
    int tx_idle_pct;
    int rx_idle_pct;
    logic pix_taken;
    logic hold_toggle;
    logic hold_seen;
    int hold_left;

    // Shadow copy of the block's configuration and state.
    logic [8:0] m_width;
    logic [8:0] m_height;
    logic [7:0] m_contrast;
    logic [7:0] m_upper [LINE_MAX];
    logic [7:0] m_middle [LINE_MAX];
    logic [7:0] m_window [6];
    logic       m_prev_edge;
    int         m_col;
    int         m_row;

    always #10 clk = ~clk;

    // Computes the output pixels one accepted input pixel produces.
    function automatic void predict_edge_pixels(logic [7:0] p, logic fs);
        int w, h, x, r, j, orow;
        int g0, g1, g2, g3, gmax, wsum;
        int a00, a10, a20, a01, a11, a21, a02, a12, a22;
        logic [7:0] top, mid;
        logic hit;
        edge_pixel_t run[$];
        w = (m_width > LINE_MAX) ? LINE_MAX : int'(m_width);
        h = (m_height > HEIGHT_MAX) ? HEIGHT_MAX : int'(m_height);
        top = 8'd0;
        mid = 8'd0;
        if (fs)
        begin
            m_col = 0;
            m_row = 0;
        end
        if (m_row >= h)
            return;
        x = m_col;
        r = m_row;

        // Shift the column through both line stores.
        if (x < LINE_MAX)
        begin
            top = m_upper[x];
            mid = m_middle[x];
            m_upper[x] = mid;
            m_middle[x] = p;
        end

        if (w >= 3 && h >= 3 && r >= 2 && x >= 2 && x <= w - 1)
        begin
            a00 = m_window[0]; a10 = m_window[1]; a20 = m_window[2];
            a01 = m_window[3]; a11 = m_window[4]; a21 = m_window[5];
            a02 = top;         a12 = mid;         a22 = p;
            g0 = a02 + a12 + a22 - a00 - a10 - a20;
            g1 = a20 + a21 + a22 - a00 - a01 - a02;
            g2 = a10 + a21 + a20 - a01 - a12 - a02;
            g3 = a12 + a21 + a22 - a01 - a10 - a00;
            if (g0 < 0) g0 = -g0;
            if (g1 < 0) g1 = -g1;
            if (g2 < 0) g2 = -g2;
            if (g3 < 0) g3 = -g3;
            gmax = g0;
            if (g1 > gmax) gmax = g1;
            if (g2 > gmax) gmax = g2;
            if (g3 > gmax) gmax = g3;
            wsum = a00 + a01 + a02 + a10 + a11 + a12 + a20 + a21 + a22;
            j = x - 1;
            orow = r - 1;
            hit = (gmax * int'(m_contrast)) > wsum;

            // The left border column shows only when the first center is an edge.
            if (j == 1 && hit)
                run.push_back('{8'(orow), 8'd0, 1'b1, 1'b0});
            if (j >= 2)
                run.push_back('{8'(orow), 8'(j - 1), m_prev_edge | hit, 1'b0});
            // The last center also closes the row, with the right border on an edge.
            if (j == w - 2)
            begin
                run.push_back('{8'(orow), 8'(j), hit, 1'b0});
                if (hit)
                    run.push_back('{8'(orow), 8'(w - 1), 1'b1, 1'b0});
            end
            if (run.size() > 0)
                run[run.size() - 1].last = 1'b1;
            foreach (run[k])
                pending_edge_pixels.push_back(run[k]);
            m_prev_edge = hit;
        end

        m_window[0] = m_window[3];
        m_window[1] = m_window[4];
        m_window[2] = m_window[5];
        m_window[3] = top;
        m_window[4] = mid;
        m_window[5] = p;

        if (x + 1 >= w)
        begin
            m_col = 0;
            m_row = r + 1;
        end
        else
            m_col = x + 1;
    endfunction

    task automatic report_fault(string msg);
        fault_count++;
        if (fault_count <= REPORT_LIMIT)
            $display("mismatch: %s", msg);
    endtask

    // Pixel driver: a new request only once the previous one was taken.
    always @(negedge clk)
    begin
        if (!rst_n)
            video_ch.valid <= 1'b0;
        else if (!video_ch.valid || pix_taken)
        begin
            if (pixels_to_send.size() > 0 && $urandom_range(99) >= tx_idle_pct)
            begin
                next_req = pixels_to_send.pop_front();
                video_ch.valid <= 1'b1;
                video_ch.pixel <= next_req.pixel;
                video_ch.frame_start <= next_req.frame_start;
            end
            else
                video_ch.valid <= 1'b0;
        end
    end

    // Result receiver with random stalls and one long hold-off on request.
    always @(negedge clk)
    begin
        if (!rst_n)
            edges_ch.ready <= 1'b0;
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            edges_ch.ready <= 1'b0;
        end
        else if (hold_toggle != hold_seen)
        begin
            hold_seen <= hold_toggle;
            hold_left <= HOLD_CYCLES;
            edges_ch.ready <= 1'b0;
        end
        else
            edges_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Monitor: predict on each accepted pixel, check each accepted result.
    always @(posedge clk)
    begin
        pix_taken <= video_ch.valid && video_ch.ready;
        if (rst_n)
        begin
            if (video_ch.valid && video_ch.ready)
            begin
                predict_edge_pixels(video_ch.pixel, video_ch.frame_start);
                pixels_accepted++;
            end
            if (edges_ch.valid && edges_ch.ready)
            begin
                if (pending_edge_pixels.size() == 0)
                    report_fault($sformatf("unexpected row %0d col %0d black %0b last %0b",
                        edges_ch.out_row, edges_ch.out_column, edges_ch.is_black,
                        edges_ch.last_in_run));
                else
                begin
                    edge_pixel_t want;
                    want = pending_edge_pixels.pop_front();
                    if (want.row !== edges_ch.out_row || want.col !== edges_ch.out_column ||
                        want.black !== edges_ch.is_black || want.last !== edges_ch.last_in_run)
                        report_fault($sformatf(
                            "expected row %0d col %0d black %0b last %0b, got %0d %0d %0b %0b",
                            want.row, want.col, want.black, want.last, edges_ch.out_row,
                            edges_ch.out_column, edges_ch.is_black, edges_ch.last_in_run));
                end
            end
        end
    end

    // Watchdog on cycles without any accepted request.
    always @(posedge clk)
    begin
        if (!rst_n || (video_ch.valid && video_ch.ready) || (edges_ch.valid && edges_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic queue_pixel(logic [7:0] p, logic fs);
        pixels_to_send.push_back('{p, fs});
        pixels_queued++;
    endtask

    // One APB write (setup then access); the shadow register follows it.
    task automatic apb_write(logic [1:0] idx, logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            emat_pkg::REG_FRAME_WIDTH:  m_width = value[8:0];
            emat_pkg::REG_FRAME_HEIGHT: m_height = value[8:0];
            emat_pkg::REG_CONTRAST:     m_contrast = value[7:0];
            default: ;
        endcase
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic configure(int w, int h, int c);
        apb_write(emat_pkg::REG_FRAME_WIDTH, 32'(w));
        apb_write(emat_pkg::REG_FRAME_HEIGHT, 32'(h));
        apb_write(emat_pkg::REG_CONTRAST, 32'(c));
    endtask

    // Wait until every pixel is in and every result is out, then let the pipe empty.
    task automatic settle();
        while (pixels_accepted != pixels_queued || pending_edge_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Content styles: noise, smooth surface around a level, or black and white.
    function automatic logic [7:0] gen_pixel(int mode, int base);
        int v;
        if (mode == 0)
            v = $urandom_range(255);
        else if (mode == 1)
            v = base + $urandom_range(8) - 4;
        else
            v = $urandom_range(1) ? 255 : 0;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return 8'(v);
    endfunction

    // Frames with random content up to count pixels, a rare early restart and some trailing pixels.
    task automatic queue_frames(int w, int h, int count);
        int fw, fh, pos, mode, base, left;
        logic fs;
        fw = (w > LINE_MAX) ? LINE_MAX : w;
        fh = (h > HEIGHT_MAX) ? HEIGHT_MAX : h;
        left = count;
        while (left > 0)
        begin
            mode = $urandom_range(2);
            base = $urandom_range(255);
            for (pos = 0; pos < fw * fh && left > 0; pos++)
            begin
                fs = (pos == 0) || ($urandom_range(99) < 2);
                queue_pixel(gen_pixel(mode, base), fs);
                left--;
            end
            if ($urandom_range(2) == 0)
                repeat ($urandom_range(1, 3)) queue_pixel(8'($urandom_range(255)), 1'b0);
        end
    endtask

    initial
    begin
        int row;
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        video_ch.valid = 1'b0;
        video_ch.pixel = 8'd0;
        video_ch.frame_start = 1'b0;
        edges_ch.ready = 1'b0;
        pix_taken = 1'b0;
        hold_toggle = 1'b0;
        hold_seen = 1'b0;
        hold_left = 0;
        pixels_queued = 0;
        pixels_accepted = 0;
        fault_count = 0;
        quiet_cycles = 0;
        m_width = emat_pkg::RST_FRAME_WIDTH;
        m_height = emat_pkg::RST_FRAME_HEIGHT;
        m_contrast = emat_pkg::RST_CONTRAST;
        foreach (m_upper[k]) m_upper[k] = 8'd0;
        foreach (m_middle[k]) m_middle[k] = 8'd0;
        foreach (m_window[k]) m_window[k] = 8'd0;
        m_prev_edge = 1'b0;
        m_col = 0;
        m_row = 0;

        // Sender idles a quarter of the time, receiver three quarters.
        tx_idle_pct = 26;
        rx_idle_pct = 75;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings and no frame start: the first pixel opens the frame.
        queue_pixel(8'd0, 1'b0);
        queue_pixel(8'd255, 1'b0);
        queue_pixel(8'($urandom_range(255)), 1'b0);
        settle();

        // Smallest frame: a flat one gives a single white pixel.
        configure(3, 3, 255);
        for (int k = 0; k < 9; k++)
            queue_pixel(8'd100, k == 0);
        // A vertical step lights the center and both border columns.
        for (row = 0; row < 3; row++)
        begin
            queue_pixel(8'd0, row == 0);
            queue_pixel(8'd0, 1'b0);
            queue_pixel(8'd255, 1'b0);
        end
        // A pixel past the last row is dropped.
        queue_pixel(8'd77, 1'b0);
        settle();

        configure(5, 4, 1);
        queue_frames(5, 4, 60);
        settle();

        // Receiver idles a quarter of the time, sender three quarters.
        tx_idle_pct = 75;
        rx_idle_pct = 26;

        // Too narrow for any center.
        configure(2, 5, 20);
        queue_frames(2, 5, 30);
        settle();

        // Zero divisor: nothing is ever an edge.
        configure(8, 6, 0);
        queue_frames(8, 6, 40);
        settle();

        // Height beyond the row counter limit; only the first rows are sent.
        configure(4, 511, 3);
        queue_frames(4, 511, 60);
        settle();

        // No idling from here on.
        tx_idle_pct = 0;
        rx_idle_pct = 0;

        // Width beyond the limit is clipped: the start of the first row of a wide frame.
        configure(511, 3, 255);
        queue_frames(511, 3, 24);
        settle();

        // Long receiver hold-off while pixels keep coming, so the input backs up.
        configure(6, 5, 8);
        hold_toggle = ~hold_toggle;
        queue_frames(6, 5, 90);
        settle();

        if (fault_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/emat_pkg.sv
rtl/emat_pixel_if.sv
rtl/emat_result_if.sv
rtl/emat_ram.sv
rtl/emat_queue.sv
rtl/emat_front.sv
rtl/emat_back.sv
rtl/edge_map_adaptive_threshold_unit.sv
tb/sv/edge_map_adaptive_threshold_unit_tb.sv
